>>> design/jetp_pkg.sv
// ----------------------------------------------------------------------------
// jetp_pkg
// shared widths, constants and types of the julia escape-time pixel pair unit
// ----------------------------------------------------------------------------
package jetp_pkg;

    // iteration limits and fixed point format
    localparam int MAX_ITERATIONS = 16;
    localparam int FRAC_BITS      = 12;
    localparam int CNT_W          = 4;
    localparam int ITER_W         = CNT_W + 1;

    // field widths
    localparam int C_W        = 14;
    localparam int STEP_W     = 8;
    localparam int ORG_W      = 19;
    localparam int SIZE_W     = 10;
    localparam int POS_W      = 9;
    localparam int COORD_W    = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    // datapath widths
    localparam int PROD_W = 2 * COORD_W;
    localparam int NEXT_W = PROD_W - FRAC_BITS + 2;

    // escape bounds
    localparam int ESC_LIMIT = 1 << (FRAC_BITS + 1);
    localparam logic [PROD_W:0] ESC_THRESH = (PROD_W + 1)'(4) << (2 * FRAC_BITS);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_C_REAL        = 3'd0,
        CFG_C_IMAG        = 3'd1,
        CFG_PIXEL_STEP    = 3'd2,
        CFG_ORIGIN_REAL   = 3'd3,
        CFG_ORIGIN_IMAG   = 3'd4,
        CFG_PAIRS_PER_ROW = 3'd5,
        CFG_ROW_COUNT     = 3'd6
    } t_cfg_reg;

    typedef logic signed [COORD_W-1:0] t_coord;

    // request into the multiplier stage
    typedef struct packed {
        logic   valid;
        logic   tag;
        t_coord x;
        t_coord y;
    } t_mul_req;

    // registered products of one point
    typedef struct packed {
        logic                     valid;
        logic                     tag;
        logic signed [PROD_W-1:0] xx;
        logic signed [PROD_W-1:0] yy;
        logic signed [PROD_W-1:0] xy;
    } t_prod;

    // outcome of one iteration step
    typedef struct packed {
        logic              done;
        logic [CNT_W-1:0]  cnt;
        logic [ITER_W-1:0] iter;
        t_coord            x;
        t_coord            y;
    } t_step_res;

endpackage

>>> design/julia_escape_time_pixel_pair_unit.sv
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_pair_unit
// julia-set escape-time renderer producing one byte of two 4-bit pixels per item
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------
//  cfg      | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//  s_axis   | in        | s_axis_tvalid / tready     | tdata[0] restart
//  m_axis   | out       | m_axis_tvalid / tready     | tdata pixel_pair, tlast
//           |           |                            | row_end, tuser frame_end
//
//  an item runs until both pixels have stopped, each at the latest at iteration step
//  16; a new item is taken only once the last one is finished
//  the two pixels share one multiplier stage in alternate cycles
//  reset is synchronous and loads the register defaults and the top-left scan
//  input is not ready while computing; a finished byte waits in the output register
//  and stalls the sequencer only while that register is full; config always ready
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_pair_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [jetp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [jetp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // [0] restart, [7:1] zero
    // output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,   // [7:0] pixel_pair
    output logic                             m_axis_tlast,   // row_end
    output logic [0:0]                       m_axis_tuser    // [0] frame_end
);
    import jetp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    localparam logic signed [ORG_W-1:0] ORIGIN_REAL_RST = -19'sd10755;
    localparam logic signed [ORG_W-1:0] ORIGIN_IMAG_RST = -19'sd7200;
    localparam logic [SIZE_W-1:0]       MAX_SIZE        = 10'd512;

    // configuration registers
    logic signed [C_W-1:0]   r_c_real;
    logic signed [C_W-1:0]   r_c_imag;
    logic [STEP_W-1:0]       r_step;
    logic signed [ORG_W-1:0] r_org_real;
    logic signed [ORG_W-1:0] r_org_imag;
    logic [SIZE_W-1:0]       r_pairs;
    logic [SIZE_W-1:0]       r_rows;

    // scan position of the next pair
    logic [POS_W-1:0] r_col;
    logic [POS_W-1:0] r_row;
    t_coord           r_pt_real;
    t_coord           r_pt_imag;

    // sequencer and per-pixel working state
    t_state            r_state;
    logic              r_phase;
    t_coord            r_x    [2];
    t_coord            r_y    [2];
    logic [ITER_W-1:0] r_iter [2];
    logic [CNT_W-1:0]  r_cnt  [2];
    logic [1:0]        r_done;
    logic              r_row_end;
    logic              r_frame_end;

    // output register
    logic       r_m_valid;
    logic [7:0] r_m_data;
    logic       r_m_last;
    logic       r_m_user;

    logic       w_s_acc;
    logic       w_m_acc;
    logic       w_restart;
    logic       w_out_load;
    t_mul_req   w_req;
    t_prod      w_prod;
    t_step_res  w_res;

    // effective start of this pair and scan advance
    logic [POS_W-1:0] n_col_eff;
    logic [POS_W-1:0] n_row_eff;
    t_coord           n_pt_real_eff;
    t_coord           n_pt_imag_eff;
    t_coord           w_org_real_ext;
    t_coord           w_org_imag_ext;
    t_coord           w_step_ext;
    logic [POS_W-1:0] w_last_col;
    logic [POS_W-1:0] w_last_row;
    logic             n_row_end;
    logic             n_frame_end;
    logic [POS_W-1:0] n_col;
    logic [POS_W-1:0] n_row;
    t_coord           n_pt_real;
    t_coord           n_pt_imag;

    // last index of a size register, with zero acting as one and large values clamped
    function automatic logic [POS_W-1:0] last_index(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] m1;
        m1 = size - SIZE_W'(1);
        if (size == '0) begin
            return '0;
        end else if (size > MAX_SIZE) begin
            return POS_W'(MAX_SIZE - SIZE_W'(1));
        end
        return m1[POS_W-1:0];
    endfunction

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign w_m_acc       = r_m_valid && m_axis_tready;
    assign w_restart     = s_axis_tdata[0];
    // finished byte moves out when the output slot is free or being emptied
    assign w_out_load    = (r_state == ST_RUN) && (r_done == 2'b11)
                        && (!r_m_valid || m_axis_tready);

    assign w_org_real_ext = {{(COORD_W-ORG_W){r_org_real[ORG_W-1]}}, r_org_real};
    assign w_org_imag_ext = {{(COORD_W-ORG_W){r_org_imag[ORG_W-1]}}, r_org_imag};
    assign w_step_ext     = {{(COORD_W-STEP_W){1'b0}}, r_step};
    assign w_last_col     = last_index(r_pairs);
    assign w_last_row     = last_index(r_rows);

    always_comb begin
        n_col_eff     = w_restart ? '0 : r_col;
        n_row_eff     = w_restart ? '0 : r_row;
        n_pt_real_eff = w_restart ? w_org_real_ext : r_pt_real;
        n_pt_imag_eff = w_restart ? w_org_imag_ext : r_pt_imag;
        n_row_end     = n_col_eff >= w_last_col;
        n_frame_end   = n_row_end && (n_row_eff >= w_last_row);
        priority if (n_frame_end) begin
            n_col     = '0;
            n_row     = '0;
            n_pt_real = w_org_real_ext;
            n_pt_imag = w_org_imag_ext;
        end else if (n_row_end) begin
            n_col     = '0;
            n_row     = n_row_eff + POS_W'(1);
            n_pt_real = w_org_real_ext;
            n_pt_imag = n_pt_imag_eff + w_step_ext;
        end else begin
            n_col     = n_col_eff + POS_W'(1);
            n_row     = n_row_eff;
            n_pt_real = n_pt_real_eff + (w_step_ext <<< 1);
            n_pt_imag = n_pt_imag_eff;
        end
    end

    // multiplier serves the pixel of this phase; the other pixel is being updated
    always_comb begin
        w_req.valid = (r_state == ST_RUN) && !r_done[r_phase];
        w_req.tag   = r_phase;
        w_req.x     = r_x[r_phase];
        w_req.y     = r_y[r_phase];
    end

    jetp_mul_stage u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_prod  (w_prod)
    );

    jetp_iter_step u_step (
        .i_prod   (w_prod),
        .i_iter   (r_iter[w_prod.tag]),
        .i_c_real (r_c_real),
        .i_c_imag (r_c_imag),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_real   <= '0;
            r_c_imag   <= '0;
            r_step     <= 8'd90;
            r_org_real <= ORIGIN_REAL_RST;
            r_org_imag <= ORIGIN_IMAG_RST;
            r_pairs    <= 10'd120;
            r_rows     <= 10'd80;
            r_col      <= '0;
            r_row      <= '0;
            r_pt_real  <= {{(COORD_W-ORG_W){ORIGIN_REAL_RST[ORG_W-1]}}, ORIGIN_REAL_RST};
            r_pt_imag  <= {{(COORD_W-ORG_W){ORIGIN_IMAG_RST[ORG_W-1]}}, ORIGIN_IMAG_RST};
            r_state    <= ST_IDLE;
            r_phase    <= 1'b0;
            r_done     <= 2'b11;
            r_iter[0]  <= '0;
            r_iter[1]  <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            // register writes, indexes past the list are dropped
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_C_REAL:        r_c_real   <= i_cfg_data[C_W-1:0];
                    CFG_C_IMAG:        r_c_imag   <= i_cfg_data[C_W-1:0];
                    CFG_PIXEL_STEP:    r_step     <= i_cfg_data[STEP_W-1:0];
                    CFG_ORIGIN_REAL:   r_org_real <= i_cfg_data[ORG_W-1:0];
                    CFG_ORIGIN_IMAG:   r_org_imag <= i_cfg_data[ORG_W-1:0];
                    CFG_PAIRS_PER_ROW: r_pairs    <= i_cfg_data[SIZE_W-1:0];
                    CFG_ROW_COUNT:     r_rows     <= i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end

            // a byte taken while the next one loads keeps the slot full
            if (w_m_acc && !w_out_load) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_s_acc) begin
                        r_col       <= n_col;
                        r_row       <= n_row;
                        r_pt_real   <= n_pt_real;
                        r_pt_imag   <= n_pt_imag;
                        r_row_end   <= n_row_end;
                        r_frame_end <= n_frame_end;
                        // left pixel at the scan point, right one a step further
                        r_x[0]      <= n_pt_real_eff;
                        r_x[1]      <= n_pt_real_eff + w_step_ext;
                        r_y[0]      <= n_pt_imag_eff;
                        r_y[1]      <= n_pt_imag_eff;
                        r_iter[0]   <= '0;
                        r_iter[1]   <= '0;
                        r_done      <= 2'b00;
                        r_phase     <= 1'b0;
                        r_state     <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_phase <= !r_phase;
                    if (w_prod.valid) begin
                        r_x[w_prod.tag]    <= w_res.x;
                        r_y[w_prod.tag]    <= w_res.y;
                        r_iter[w_prod.tag] <= w_res.iter;
                        r_cnt[w_prod.tag]  <= w_res.cnt;
                        r_done[w_prod.tag] <= w_res.done;
                    end
                    if (w_out_load) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {r_cnt[0], r_cnt[1]};
                        r_m_last  <= r_row_end;
                        r_m_user  <= r_frame_end;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_data;
    assign m_axis_tlast    = r_m_last;
    assign m_axis_tuser[0] = r_m_user;

`ifndef SYNTH
    // no products in flight once the sequencer has gone idle
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |=> !w_prod.valid)
        else $error("product in flight while idle");

    // iteration counters never pass the limit
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_iter[0] <= ITER_W'(MAX_ITERATIONS)) && (r_iter[1] <= ITER_W'(MAX_ITERATIONS)))
        else $error("iteration counter out of range");

    // a new byte appears only as the sequencer finishes both pixels
    a_out_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> ($past(r_state) == ST_RUN) && ($past(r_done) == 2'b11))
        else $error("output loaded without a finished pair");

    // the multiplier never serves a pixel that has already stopped
    a_no_done_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.valid |-> !r_done[w_req.tag])
        else $error("finished pixel sent to multiplier");
`endif

endmodule

>>> design/jetp_mul_stage.sv
// ----------------------------------------------------------------------------
// jetp_mul_stage
// registered squares and cross product of one point, shared by both pixels
// ----------------------------------------------------------------------------
module jetp_mul_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  jetp_pkg::t_mul_req i_req,
    output jetp_pkg::t_prod    o_prod
);
    import jetp_pkg::*;

    logic signed [PROD_W-1:0] w_xx;
    logic signed [PROD_W-1:0] w_yy;
    logic signed [PROD_W-1:0] w_xy;
    t_prod                    r_prod;

    assign w_xx = i_req.x * i_req.x;
    assign w_yy = i_req.y * i_req.y;
    assign w_xy = i_req.x * i_req.y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod.valid <= 1'b0;
        end else begin
            r_prod.valid <= i_req.valid;
        end
        r_prod.tag <= i_req.tag;
        r_prod.xx  <= w_xx;
        r_prod.yy  <= w_yy;
        r_prod.xy  <= w_xy;
    end

    assign o_prod = r_prod;

endmodule

>>> design/jetp_iter_step.sv
// ----------------------------------------------------------------------------
// jetp_iter_step
// one escape-time iteration from registered products: next point and stop test
// ----------------------------------------------------------------------------
module jetp_iter_step (
    input  jetp_pkg::t_prod              i_prod,
    input  logic [jetp_pkg::ITER_W-1:0]  i_iter,
    input  logic signed [jetp_pkg::C_W-1:0] i_c_real,
    input  logic signed [jetp_pkg::C_W-1:0] i_c_imag,
    output jetp_pkg::t_step_res          o_res
);
    import jetp_pkg::*;

    localparam logic signed [NEXT_W-1:0] LIM_P = NEXT_W'(ESC_LIMIT);
    localparam logic signed [NEXT_W-1:0] LIM_N = -LIM_P;

    logic signed [PROD_W:0]           w_diff;
    logic signed [PROD_W-FRAC_BITS:0] w_dsh;
    logic signed [PROD_W-FRAC_BITS:0] w_xysh;
    logic signed [NEXT_W-1:0]         w_cr_ext;
    logic signed [NEXT_W-1:0]         w_ci_ext;
    logic signed [NEXT_W-1:0]         w_x_ext;
    logic signed [NEXT_W-1:0]         w_y_ext;
    logic signed [NEXT_W-1:0]         w_x_next;
    logic signed [NEXT_W-1:0]         w_y_next;
    logic [PROD_W:0]                  w_mag2;
    logic                             w_big;
    logic                             w_far;
    logic [ITER_W-1:0]                w_iter_m1;

    assign w_diff   = {i_prod.xx[PROD_W-1], i_prod.xx} - {i_prod.yy[PROD_W-1], i_prod.yy};
    // arithmetic shifts as bit selects
    assign w_dsh    = w_diff[PROD_W:FRAC_BITS];
    assign w_xysh   = i_prod.xy[PROD_W-1:FRAC_BITS-1];
    assign w_cr_ext = {{(NEXT_W-C_W){i_c_real[C_W-1]}}, i_c_real};
    assign w_ci_ext = {{(NEXT_W-C_W){i_c_imag[C_W-1]}}, i_c_imag};
    assign w_x_ext  = {w_dsh[PROD_W-FRAC_BITS], w_dsh};
    assign w_y_ext  = {w_xysh[PROD_W-FRAC_BITS], w_xysh};
    assign w_x_next = w_x_ext + w_cr_ext;
    assign w_y_next = w_y_ext + w_ci_ext;

    // squares are never negative
    assign w_mag2    = {1'b0, i_prod.xx} + {1'b0, i_prod.yy};
    assign w_far     = w_mag2 > ESC_THRESH;
    assign w_big     = (w_x_next > LIM_P) || (w_x_next < LIM_N)
                    || (w_y_next > LIM_P) || (w_y_next < LIM_N);
    assign w_iter_m1 = i_iter - ITER_W'(1);

    always_comb begin
        o_res.x    = w_x_next[COORD_W-1:0];
        o_res.y    = w_y_next[COORD_W-1:0];
        o_res.iter = i_iter + ITER_W'(1);
        o_res.done = 1'b0;
        o_res.cnt  = i_iter[CNT_W-1:0];
        priority if (i_iter == ITER_W'(MAX_ITERATIONS)) begin
            // counter holds at the limit
            o_res.iter = i_iter;
            o_res.done = 1'b1;
            o_res.cnt  = CNT_W'(MAX_ITERATIONS - 1);
        end else if ((i_iter != '0) && w_far) begin
            // previous iteration landed outside the radius
            o_res.done = 1'b1;
            o_res.cnt  = w_iter_m1[CNT_W-1:0];
        end else if (w_big) begin
            o_res.done = 1'b1;
            o_res.cnt  = i_iter[CNT_W-1:0];
        end else begin
            o_res.done = 1'b0;
        end
    end

endmodule
